// ===== design/gpr_pkg.sv =====
package gpr_pkg;

    // Register map of the port.
    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_OTYPE    = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_INDATA   = 4'd4,
        REG_OUTDATA  = 4'd5,
        REG_SETRESET = 4'd6,
        REG_LOCK     = 4'd7,
        REG_AFLOW    = 4'd8,
        REG_AFHIGH   = 4'd9,
        REG_RESET    = 4'd10
    } reg_idx_t;

    // Handshake state of the controller: result register empty or full.
    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } ctrl_state_t;

    // Progress through the lock key sequence.
    typedef enum logic [1:0] {
        LK_IDLE    = 2'd0,
        LK_GOT_SET = 2'd1,
        LK_GOT_CLR = 2'd2
    } lock_step_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     write;
        reg_idx_t sel;
    } gpr_cmd_t;

    localparam int KEY_BIT  = 16;

    localparam logic [1:0] MODE_OUTPUT    = 2'b01;
    localparam logic [1:0] MODE_ALTERNATE = 2'b10;
    localparam logic [1:0] PULL_UP        = 2'b01;
    localparam logic [1:0] PULL_DOWN      = 2'b10;

    // One bit per pin widened to two bits per pin.
    function automatic logic [31:0] spread2(input logic [15:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            r[2*i +: 2] = {2{m[i]}};
        end
        return r;
    endfunction

    // Eight pins widened to four bits per pin.
    function automatic logic [31:0] spread4(input logic [7:0] m);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

    function automatic logic [31:0] merge(input logic [31:0] old_val,
                                          input logic [31:0] data,
                                          input logic [31:0] mask);
        return (old_val & ~mask) | (data & mask);
    endfunction

    // Per pin, 1 where the two-bit field equals code.
    function automatic logic [15:0] match2(input logic [31:0] f, input logic [1:0] code);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            r[i] = (f[2*i +: 2] == code);
        end
        return r;
    endfunction

endpackage

// ===== design/gpr_req_if.sv =====
interface gpr_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pad_levels;

    modport source (output valid, action, reg_index, write_data, pad_levels, input ready);
    modport sink   (input valid, action, reg_index, write_data, pad_levels, output ready);
endinterface

// ===== design/gpr_rsp_if.sv =====
interface gpr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pad_out_level;
    logic [15:0] pad_drive_enable;
    logic [15:0] pull_up_enable;
    logic [15:0] pull_down_enable;
    logic [15:0] open_drain_enable;
    logic        lock_active;

    modport source (output valid, read_data, pad_out_level, pad_drive_enable,
                    pull_up_enable, pull_down_enable, open_drain_enable, lock_active,
                    input ready);
    modport sink   (input valid, read_data, pad_out_level, pad_drive_enable,
                    pull_up_enable, pull_down_enable, open_drain_enable, lock_active,
                    output ready);
endinterface

// ===== design/gpr_ctrl.sv =====
module gpr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  logic [3:0]       reg_index,
    output logic             out_valid,
    input  logic             out_ready,
    output gpr_pkg::gpr_cmd_t cmd
);
    import gpr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new word may enter when the result register is empty or is being drained.
    always_comb
    begin
        in_ready  = (state_reg == ST_EMPTY) || out_ready;
        out_valid = (state_reg == ST_FULL);
        accept    = in_valid && in_ready;
        cmd.load  = accept;
        cmd.write = action;
        cmd.sel   = reg_idx_t'(reg_index);
        case (state_reg)
            ST_EMPTY: state_next = accept ? ST_FULL : ST_EMPTY;
            ST_FULL:  state_next = (out_ready && !accept) ? ST_EMPTY : ST_FULL;
            default:  state_next = ST_EMPTY;
        endcase
    end

endmodule

// ===== design/gpr_datapath.sv =====
module gpr_datapath #(
    parameter int PIN_COUNT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gpr_pkg::gpr_cmd_t cmd,
    input  logic [31:0]       write_data,
    input  logic [15:0]       pad_levels,
    output logic [31:0]       read_data,
    output logic [15:0]       pad_out_level,
    output logic [15:0]       pad_drive_enable,
    output logic [15:0]       pull_up_enable,
    output logic [15:0]       pull_down_enable,
    output logic [15:0]       open_drain_enable,
    output logic              lock_active
);
    import gpr_pkg::*;

    localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);

    logic [31:0] mode_reg, mode_next;
    logic [15:0] otype_reg, otype_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] pull_reg, pull_next;
    logic [15:0] level_reg, level_next;
    logic [31:0] afl_reg, afl_next;
    logic [31:0] afh_reg, afh_next;
    logic [15:0] locked_reg, locked_next;
    logic        engaged_reg, engaged_next;
    lock_step_t  step_reg, step_next;
    logic [15:0] pend_reg, pend_next;
    logic [31:0] rd_reg, rd_next;

    logic [15:0] free_mask;
    logic        key;
    logic [15:0] key_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            otype_reg   <= '0;
            speed_reg   <= '0;
            pull_reg    <= '0;
            level_reg   <= '0;
            afl_reg     <= '0;
            afh_reg     <= '0;
            locked_reg  <= '0;
            engaged_reg <= 1'b0;
            step_reg    <= LK_IDLE;
            pend_reg    <= '0;
            rd_reg      <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            otype_reg   <= otype_next;
            speed_reg   <= speed_next;
            pull_reg    <= pull_next;
            level_reg   <= level_next;
            afl_reg     <= afl_next;
            afh_reg     <= afh_next;
            locked_reg  <= locked_next;
            engaged_reg <= engaged_next;
            step_reg    <= step_next;
            pend_reg    <= pend_next;
            rd_reg      <= rd_next;
        end
    end

    always_comb
    begin
        free_mask    = PIN_MASK & ~locked_reg;
        key          = write_data[KEY_BIT];
        key_mask     = write_data[15:0];
        mode_next    = mode_reg;
        otype_next   = otype_reg;
        speed_next   = speed_reg;
        pull_next    = pull_reg;
        level_next   = level_reg;
        afl_next     = afl_reg;
        afh_next     = afh_reg;
        locked_next  = locked_reg;
        engaged_next = engaged_reg;
        step_next    = step_reg;
        pend_next    = pend_reg;
        rd_next      = rd_reg;
        if (cmd.load)
        begin
            rd_next = '0;
            if (cmd.write)
            begin
                case (cmd.sel)
                    REG_MODE:    mode_next  = merge(mode_reg, write_data, spread2(free_mask));
                    REG_OTYPE:   otype_next = (otype_reg & ~free_mask)
                                              | (write_data[15:0] & free_mask);
                    REG_SPEED:   speed_next = merge(speed_reg, write_data, spread2(free_mask));
                    REG_PULL:    pull_next  = merge(pull_reg, write_data, spread2(free_mask));
                    REG_OUTDATA: level_next = write_data[15:0] & PIN_MASK;
                    REG_SETRESET:
                    begin
                        // Set wins over reset for the same pin.
                        level_next = (level_reg & ~(write_data[31:16] & PIN_MASK))
                                     | (write_data[15:0] & PIN_MASK);
                    end
                    REG_LOCK:
                    begin
                        if (!engaged_reg)
                        begin
                            if (step_reg == LK_GOT_SET && !key && key_mask == pend_reg)
                            begin
                                step_next = LK_GOT_CLR;
                            end
                            else if (step_reg == LK_GOT_CLR && key && key_mask == pend_reg)
                            begin
                                engaged_next = 1'b1;
                                locked_next  = key_mask & PIN_MASK;
                                step_next    = LK_IDLE;
                            end
                            else if (key)
                            begin
                                step_next = LK_GOT_SET;
                                pend_next = key_mask;
                            end
                            else
                            begin
                                step_next = LK_IDLE;
                                pend_next = '0;
                            end
                        end
                    end
                    REG_AFLOW:   afl_next   = merge(afl_reg, write_data, spread4(free_mask[7:0]));
                    REG_AFHIGH:  afh_next   = merge(afh_reg, write_data, spread4(free_mask[15:8]));
                    REG_RESET:   level_next = level_reg & ~(write_data[15:0] & PIN_MASK);
                    default:     ;
                endcase
            end
            else
            begin
                case (cmd.sel)
                    REG_MODE:    rd_next = mode_reg;
                    REG_OTYPE:   rd_next = {16'd0, otype_reg};
                    REG_SPEED:   rd_next = speed_reg;
                    REG_PULL:    rd_next = pull_reg;
                    REG_INDATA:  rd_next = {16'd0, pad_levels & PIN_MASK};
                    REG_OUTDATA: rd_next = {16'd0, level_reg};
                    REG_LOCK:    rd_next = {15'd0, engaged_reg, locked_reg};
                    REG_AFLOW:   rd_next = afl_reg;
                    REG_AFHIGH:  rd_next = afh_reg;
                    default:     rd_next = '0;
                endcase
            end
        end
    end

    // Pad controls follow the stored fields of the last accepted word.
    assign read_data         = rd_reg;
    assign pad_out_level     = level_reg;
    assign pad_drive_enable  = (match2(mode_reg, MODE_OUTPUT) | match2(mode_reg, MODE_ALTERNATE))
                               & PIN_MASK;
    assign pull_up_enable    = match2(pull_reg, PULL_UP) & PIN_MASK;
    assign pull_down_enable  = match2(pull_reg, PULL_DOWN) & PIN_MASK;
    assign open_drain_enable = otype_reg & PIN_MASK;
    assign lock_active       = engaged_reg;

endmodule

// ===== design/gpio_port_register_block_unit.sv =====
// Channel | Role   | Word carried
// --------+--------+---------------------------------------------------------------
// req     | sink   | action, reg_index, write_data, pad_levels (one bus access)
// rsp     | source | read_data and the pad controls after that access
//
// Each accepted word updates the port registers and loads the result register
// at the same clock edge, and the result is offered on rsp from the next cycle.
// A new word is taken in every cycle while rsp drains. When rsp stalls, the
// single result register holds and req.ready falls. Reset is asynchronous and
// clears every port register and the lock.
module gpio_port_register_block_unit #(
    parameter int PIN_COUNT = 16
) (
    input logic   clk,
    input logic   rst_n,
    gpr_req_if.sink   req,
    gpr_rsp_if.source rsp
);
    import gpr_pkg::*;

    gpr_cmd_t cmd;

    // The controller only tracks whether the result register is occupied and
    // decodes the access into a command for the datapath.
    gpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .action    (req.action),
        .reg_index (req.reg_index),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the port registers, the lock sequencer and the
    // registered read data; pad controls are decoded from the stored fields.
    gpr_datapath #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .write_data        (req.write_data),
        .pad_levels        (req.pad_levels),
        .read_data         (rsp.read_data),
        .pad_out_level     (rsp.pad_out_level),
        .pad_drive_enable  (rsp.pad_drive_enable),
        .pull_up_enable    (rsp.pull_up_enable),
        .pull_down_enable  (rsp.pull_down_enable),
        .open_drain_enable (rsp.open_drain_enable),
        .lock_active       (rsp.lock_active)
    );

endmodule

// ===== design/gpr_checker.sv =====
module gpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        lock_active
);

    // A stalled result keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result changed while stalled");

    // Every accepted word produces a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word gave no result");

    // No new word while an untaken result is pending.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("word accepted over a pending result");

    // A write returns zero read data.
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> read_data == 32'd0)
        else $error("write returned nonzero read data");

    // Only reset releases the lock.
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        lock_active |=> lock_active)
        else $error("lock released without reset");

endmodule

bind gpio_port_register_block_unit gpr_checker u_gpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_action   (req.action),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .read_data   (rsp.read_data),
    .lock_active (rsp.lock_active)
);

// ===== tb/gpio_port_register_block_unit_test.sv =====
`timescale 1ns / 100ps

module gpio_port_register_block_unit_test;

    import gpr_pkg::*;

    localparam bit         ACT_READ     = 1'b0;
    localparam bit         ACT_WRITE    = 1'b1;
    localparam logic [3:0] IDX_UNUSED_LO = 4'd11;
    localparam logic [3:0] IDX_UNUSED_HI = 4'd15;
    localparam int         LONG_HOLD    = 60;

    // One bus access as it goes onto the request channel.
    typedef struct {
        bit          wr;
        logic [3:0]  idx;
        logic [31:0] data;
        logic [15:0] pads;
    } access_t;

    // The response word: the read data and the pad controls after the access.
    typedef struct {
        logic [31:0] rd;
        logic [15:0] out_level;
        logic [15:0] drive;
        logic [15:0] pull_up;
        logic [15:0] pull_down;
        logic [15:0] open_drain;
        logic        lock;
    } port_view_t;

    // A directed row. Where known is set, rd is typed in by hand and it replaces
    // the read data the port model predicts.
    typedef struct {
        bit          wr;
        logic [3:0]  idx;
        logic [31:0] data;
        logic [15:0] pads;
        bit          known;
        logic [31:0] rd;
    } row_t;

    logic clk;
    logic rst_n;

    gpr_req_if req_bus ();
    gpr_rsp_if rsp_bus ();

    gpio_port_register_block_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Port model state. These mirror the registers of the block.
    logic [31:0] mode_m;
    logic [15:0] otype_m;
    logic [31:0] speed_m;
    logic [31:0] pull_m;
    logic [15:0] outlvl_m;
    logic [31:0] af_lo_m;
    logic [31:0] af_hi_m;
    logic [15:0] locked_m;
    logic        lock_on_m;
    lock_step_t  lock_step_m;
    logic [15:0] lock_mask_m;

    // Responses the block still owes, oldest first.
    port_view_t expected_views [$];

    int mismatches     = 0;
    int words_sent     = 0;
    int responses_seen = 0;
    int directed_count = 0;

    // When steady is set, neither side idles any more. While keep_lock_open is
    // set, the random stimulus never finishes the lock key sequence. This keeps
    // the port unlocked for the first part of the run, since only reset can
    // release the lock. The main sequence raises long_hold_req, and the response
    // side then holds off for a long stretch.
    bit steady         = 1'b0;
    bit keep_lock_open = 1'b1;
    bit long_hold_req  = 1'b0;

    // The directed part. It starts from reset, then writes each register, several at
    // their extremes. It also covers the write-only and read-only words, set and reset
    // together, the unused indices, and a lock sequence that is restarted before
    // it can complete.
    row_t directed_rows [$] = '{
        '{ACT_READ,  REG_MODE,      32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000},
        '{ACT_READ,  REG_LOCK,      32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000},
        '{ACT_WRITE, REG_MODE,      32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_MODE,      32'h0000_0000, 16'h0000, 1'b1, 32'hFFFF_FFFF},
        '{ACT_WRITE, REG_OTYPE,     32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_OTYPE,     32'h0000_0000, 16'h0000, 1'b1, 32'h0000_FFFF},
        '{ACT_WRITE, REG_SPEED,     32'hA5A5_A5A5, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_PULL,      32'h9999_9999, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_INDATA,    32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_FFFF},
        '{ACT_WRITE, REG_INDATA,    32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_INDATA,    32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0000_0000},
        '{ACT_WRITE, REG_OUTDATA,   32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_OUTDATA,   32'h0000_0000, 16'h0000, 1'b1, 32'h0000_FFFF},
        '{ACT_WRITE, REG_RESET,     32'h0000_00FF, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_SETRESET,  32'hF0F0_0FF0, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_SETRESET,  32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000},
        '{ACT_READ,  REG_OUTDATA,   32'h0000_0000, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_AFLOW,     32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_AFHIGH,    32'h1234_5678, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_AFHIGH,    32'h0000_0000, 16'h0000, 1'b1, 32'h1234_5678},
        '{ACT_WRITE, IDX_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0},
        '{ACT_READ,  IDX_UNUSED_HI, 32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000},
        '{ACT_WRITE, REG_LOCK,      32'hFFFF_00F0, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_LOCK,      32'h0000_00F0, 16'h0000, 1'b0, 32'h0},
        '{ACT_WRITE, REG_LOCK,      32'h0001_0F00, 16'h0000, 1'b0, 32'h0},
        '{ACT_READ,  REG_LOCK,      32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000}
    };

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
    end

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH response %0d %s: got %h expected %h",
                 responses_seen, what, got, want);
        mismatches++;
    endtask

    // Applies one access to the port model and returns the response the block
    // must produce for it. A field is protected by its pin's lock bit, so every
    // configuration write goes through a mask built from the unlocked pins.
    function automatic port_view_t apply_access(input access_t a);
        port_view_t  v;
        logic [15:0] open_pins;
        logic [31:0] mask2;
        logic [31:0] mask4_lo;
        logic [31:0] mask4_hi;
        logic        key;
        logic [15:0] key_mask;
        open_pins = ~locked_m;
        for (int i = 0; i < 16; i++)
        begin
            mask2[2*i +: 2] = {2{open_pins[i]}};
        end
        for (int i = 0; i < 8; i++)
        begin
            mask4_lo[4*i +: 4] = {4{open_pins[i]}};
            mask4_hi[4*i +: 4] = {4{open_pins[i+8]}};
        end
        key      = a.data[KEY_BIT];
        key_mask = a.data[15:0];
        v.rd     = '0;
        if (a.wr)
        begin
            case (a.idx)
                REG_MODE:     mode_m   = (mode_m & ~mask2) | (a.data & mask2);
                REG_OTYPE:    otype_m  = (otype_m & ~open_pins) | (a.data[15:0] & open_pins);
                REG_SPEED:    speed_m  = (speed_m & ~mask2) | (a.data & mask2);
                REG_PULL:     pull_m   = (pull_m & ~mask2) | (a.data & mask2);
                REG_OUTDATA:  outlvl_m = a.data[15:0];
                // Set is applied after reset, so a pin named in both halves ends up set.
                REG_SETRESET: outlvl_m = (outlvl_m & ~a.data[31:16]) | a.data[15:0];
                REG_AFLOW:    af_lo_m  = (af_lo_m & ~mask4_lo) | (a.data & mask4_lo);
                REG_AFHIGH:   af_hi_m  = (af_hi_m & ~mask4_hi) | (a.data & mask4_hi);
                REG_RESET:    outlvl_m = outlvl_m & ~a.data[15:0];
                REG_LOCK:
                begin
                    // Key 1, key 0, key 1 with one mask engages the lock. Any write
                    // out of order ends the sequence, and a key 1 write restarts it.
                    if (!lock_on_m)
                    begin
                        if (lock_step_m == LK_GOT_SET && !key && key_mask == lock_mask_m)
                        begin
                            lock_step_m = LK_GOT_CLR;
                        end
                        else if (lock_step_m == LK_GOT_CLR && key && key_mask == lock_mask_m)
                        begin
                            lock_on_m   = 1'b1;
                            locked_m    = key_mask;
                            lock_step_m = LK_IDLE;
                        end
                        else if (key)
                        begin
                            lock_step_m = LK_GOT_SET;
                            lock_mask_m = key_mask;
                        end
                        else
                        begin
                            lock_step_m = LK_IDLE;
                            lock_mask_m = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            case (a.idx)
                REG_MODE:    v.rd = mode_m;
                REG_OTYPE:   v.rd = {16'h0, otype_m};
                REG_SPEED:   v.rd = speed_m;
                REG_PULL:    v.rd = pull_m;
                REG_INDATA:  v.rd = {16'h0, a.pads};
                REG_OUTDATA: v.rd = {16'h0, outlvl_m};
                REG_LOCK:    v.rd = {15'h0, lock_on_m, locked_m};
                REG_AFLOW:   v.rd = af_lo_m;
                REG_AFHIGH:  v.rd = af_hi_m;
                default:     v.rd = '0;
            endcase
        end
        for (int i = 0; i < 16; i++)
        begin
            v.drive[i]     = (mode_m[2*i +: 2] == MODE_OUTPUT) ||
                             (mode_m[2*i +: 2] == MODE_ALTERNATE);
            v.pull_up[i]   = (pull_m[2*i +: 2] == PULL_UP);
            v.pull_down[i] = (pull_m[2*i +: 2] == PULL_DOWN);
        end
        v.out_level  = outlvl_m;
        v.open_drain = otype_m;
        v.lock       = lock_on_m;
        return v;
    endfunction

    // Builds a random access. Lock writes often reuse the pending mask, so that
    // sequences move forward on their own. When no_lock_write is set, a lock
    // write becomes a lock read, which leaves a sequence in progress untouched.
    function automatic access_t random_access(input bit no_lock_write);
        access_t a;
        a.wr  = 1'($urandom_range(0, 1));
        a.idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
        case ($urandom_range(0, 7))
            0:       a.data = 32'h0000_0000;
            1:       a.data = 32'hFFFF_FFFF;
            default: a.data = $urandom;
        endcase
        a.pads = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        if (a.wr && a.idx == REG_LOCK)
        begin
            if (no_lock_write)
            begin
                a.wr = ACT_READ;
            end
            else
            begin
                if ($urandom_range(0, 1))
                begin
                    a.data[15:0] = lock_mask_m;
                end
                if (keep_lock_open && !lock_on_m && lock_step_m == LK_GOT_CLR &&
                    a.data[KEY_BIT] && a.data[15:0] == lock_mask_m)
                begin
                    a.data[0] = ~a.data[0];
                end
            end
        end
        return a;
    endfunction

    // Offers one word and holds it until the block takes it. The word is then
    // applied to the model at the edge where it was accepted.
    task automatic send_access(input access_t a, input bit known, input logic [31:0] known_rd);
        port_view_t v;
        req_bus.valid      <= 1'b1;
        req_bus.action     <= a.wr;
        req_bus.reg_index  <= a.idx;
        req_bus.write_data <= a.data;
        req_bus.pad_levels <= a.pads;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        v = apply_access(a);
        if (known)
        begin
            v.rd = known_rd;
        end
        expected_views.push_back(v);
        words_sent++;
    endtask

    // Sometimes drops valid for a random burst, unless steady is set.
    task automatic idle_gap();
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Stops offering words until every owed response has come back.
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Runs a key sequence with random mask and junk in bits 31..17. Other
    // registers are accessed between the steps. Unless complete is set, the
    // sequence is broken at its second or third step, either by a wrong key
    // or by a changed mask.
    task automatic run_lock_sequence(input bit complete);
        access_t     a;
        logic [15:0] m;
        int          break_at;
        m        = 16'($urandom);
        break_at = complete ? 3 : $urandom_range(1, 2);
        for (int step = 0; step < 3; step++)
        begin
            repeat ($urandom_range(0, 2))
            begin
                send_access(random_access(1'b1), 1'b0, '0);
                idle_gap();
            end
            a      = random_access(1'b1);
            a.wr   = ACT_WRITE;
            a.idx  = REG_LOCK;
            a.data = {15'($urandom), step != 1, m};
            if (step == break_at)
            begin
                if ($urandom_range(0, 1))
                begin
                    a.data[KEY_BIT] = ~a.data[KEY_BIT];
                end
                else
                begin
                    a.data[$urandom_range(0, 15)] ^= 1'b1;
                end
            end
            send_access(a, 1'b0, '0);
            idle_gap();
        end
    endtask

    // Response side. Each response taken is checked against the oldest owed word.
    // Ready then drops in random bursts, or for one long stretch on request, so
    // the single result register fills and the request side stalls.
    initial
    begin
        port_view_t want;
        int         hold_left;
        hold_left     = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                responses_seen++;
                if (expected_views.size() == 0)
                begin
                    report_mismatch("response with nothing owed", rsp_bus.read_data, '0);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (rsp_bus.read_data !== want.rd)
                        report_mismatch("read_data", rsp_bus.read_data, want.rd);
                    if (rsp_bus.pad_out_level !== want.out_level)
                        report_mismatch("pad_out_level", 32'(rsp_bus.pad_out_level),
                                        32'(want.out_level));
                    if (rsp_bus.pad_drive_enable !== want.drive)
                        report_mismatch("pad_drive_enable", 32'(rsp_bus.pad_drive_enable),
                                        32'(want.drive));
                    if (rsp_bus.pull_up_enable !== want.pull_up)
                        report_mismatch("pull_up_enable", 32'(rsp_bus.pull_up_enable),
                                        32'(want.pull_up));
                    if (rsp_bus.pull_down_enable !== want.pull_down)
                        report_mismatch("pull_down_enable", 32'(rsp_bus.pull_down_enable),
                                        32'(want.pull_down));
                    if (rsp_bus.open_drain_enable !== want.open_drain)
                        report_mismatch("open_drain_enable", 32'(rsp_bus.open_drain_enable),
                                        32'(want.open_drain));
                    if (rsp_bus.lock_active !== want.lock)
                        report_mismatch("lock_active", 32'(rsp_bus.lock_active),
                                        32'(want.lock));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                hold_left     = $urandom_range(0, 10);
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed rows, then random traffic in three parts.
    // The port stays unlocked in the first part. The lock engages at the start
    // of the second part. The third part runs with no idling on either side.
    initial
    begin
        access_t a;
        mode_m      = '0;
        otype_m     = '0;
        speed_m     = '0;
        pull_m      = '0;
        outlvl_m    = '0;
        af_lo_m     = '0;
        af_hi_m     = '0;
        locked_m    = '0;
        lock_on_m   = 1'b0;
        lock_step_m = LK_IDLE;
        lock_mask_m = '0;

        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.action     <= ACT_READ;
        req_bus.reg_index  <= REG_MODE;
        req_bus.write_data <= '0;
        req_bus.pad_levels <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            a.wr   = directed_rows[r].wr;
            a.idx  = directed_rows[r].idx;
            a.data = directed_rows[r].data;
            a.pads = directed_rows[r].pads;
            send_access(a, directed_rows[r].known, directed_rows[r].rd);
            idle_gap();
        end
        directed_count = words_sent;
        drain_responses();

        // Unlocked part. Partway through, the response side holds off for a
        // long stretch while words keep coming. Later the request side pauses
        // until every response is back.
        for (int i = 0; i < 900; i++)
        begin
            if (i == 300)
            begin
                long_hold_req = 1'b1;
            end
            if (i == 600)
            begin
                drain_responses();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                run_lock_sequence(1'b0);
            end
            else
            begin
                send_access(random_access(1'b0), 1'b0, '0);
                idle_gap();
            end
        end

        // Locked part. Configuration writes must leave the locked pins alone,
        // and further lock writes are ignored.
        keep_lock_open = 1'b0;
        run_lock_sequence(1'b1);
        for (int i = 0; i < 400; i++)
        begin
            send_access(random_access(1'b0), 1'b0, '0);
            idle_gap();
        end

        // Back-to-back part: one word per cycle in each direction.
        steady = 1'b1;
        for (int i = 0; i < 250; i++)
        begin
            send_access(random_access(1'b0), 1'b0, '0);
        end

        drain_responses();
        repeat (8) @(posedge clk);
        if (expected_views.size() != 0)
        begin
            report_mismatch("responses never returned", 32'(expected_views.size()), 32'd0);
        end

        $display("Run covered %0d accesses (%0d directed) and %0d checked responses.",
                 words_sent, directed_count, responses_seen);
        $display("Lock engaged on pin mask %h; %0d mismatches.", locked_m, mismatches);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog in case the handshake hangs.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
